// ===== sv/fbsc_pkg.sv =====
// Shared types and constants for the frame buffer swap chain.
`default_nettype none
package fbsc_pkg;

  localparam int IDX_W   = 5;
  localparam int CNT_W   = 6;
  localparam int STAMP_W = 32;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [CNT_W-1:0] BUFFER_COUNT_RESET = 6'd32;

  // Word index of the ring size register
  localparam logic REG_BUFFER_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_SUBMIT  = 2'd1,
    OP_VBLANK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  // Next buffer in a ring of n buffers; wraps to zero at or past the end.
  function automatic logic [CNT_W-1:0] ring_after(input logic [CNT_W-1:0] idx,
                                                  input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] inc;
    inc = idx + 1'b1;
    return (inc >= n) ? '0 : inc;
  endfunction

endpackage
`default_nettype wire

// ===== sv/frame_buffer_swap_chain_unit.sv =====
// Frame buffer swap chain: acquire, submit and vertical blank over a ring of buffers.
//
// One item is taken at a time. An acquire walks the ring one buffer per cycle with a
// single free-test unit, then passes to the output state; a submit reads the stamp
// window entry at acceptance, then does the span subtract and write-back; a vertical
// blank updates the showing buffer, and an unused operation goes straight to output.
// The result is loaded into the output register at the edge that returns the unit to
// idle, so in_tready rises together with out_tvalid; the register holds the result until
// taken while the next item runs, and that item waits in its last cycle while it is full.
// The stamp window has a valid bit per entry, so it needs no clearing pass after reset.
`default_nettype none
module frame_buffer_swap_chain_unit
  import fbsc_pkg::*;
#(
  parameter int MAX_BUFFERS   = 32,
  parameter int WINDOW_FRAMES = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input items
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [39:0]       in_tdata,   // buffer_index[4:0], timestamp[36:5], zero pad
  input  wire logic [1:0]        in_tuser,   // operation[1:0]
  // result items
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [47:0]            out_tdata,  // granted_index[4:0], showing_index[9:5],
                                             // window_ticks[41:10], zero pad
  output logic [1:0]             out_tuser,  // status[1:0]
  // configuration
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int BI_W = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int SL_W = $clog2(WINDOW_FRAMES);
  localparam logic [SL_W-1:0] SLOT_LAST = SL_W'(WINDOW_FRAMES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SUBMIT,
    S_VBLANK,
    S_OUT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         buffer_count_r, buffer_count_nxt;
  logic [IDX_W-1:0]         showing_r, showing_nxt;
  logic [MAX_BUFFERS-1:0]   locked_r, locked_nxt;
  logic [MAX_BUFFERS-1:0]   ready_r, ready_nxt;
  logic [WINDOW_FRAMES-1:0] valid_r, valid_nxt;
  logic [SL_W-1:0]          slot_r, slot_nxt;
  logic [STAMP_W-1:0]       span_r, span_nxt;
  logic [IDX_W-1:0]         cand_r, cand_nxt;
  logic [CNT_W-1:0]         steps_r, steps_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [STAMP_W-1:0]       stamp_r, stamp_nxt;
  status_t                  status_r, status_nxt;
  logic [IDX_W-1:0]         granted_r, granted_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [IDX_W-1:0]         out_granted_r, out_granted_nxt;
  logic [IDX_W-1:0]         out_showing_r, out_showing_nxt;
  logic [STAMP_W-1:0]       out_span_r, out_span_nxt;

  logic [STAMP_W-1:0]       stamp_mem [WINDOW_FRAMES];
  logic [STAMP_W-1:0]       rd_data_r;
  logic                     mem_we;

  logic [CNT_W-1:0]         ring_n;
  logic                     in_acc;
  logic                     cfg_wr;
  logic                     cand_busy;
  logic [CNT_W-1:0]         cand_after;
  logic [CNT_W-1:0]         show_after;
  logic [CNT_W-1:0]         steps_inc;

  assign in_acc = in_tvalid && in_tready;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    if (buffer_count_r == '0) begin
      ring_n = CNT_W'(1);
    end else if (buffer_count_r > CNT_W'(MAX_BUFFERS)) begin
      ring_n = CNT_W'(MAX_BUFFERS);
    end else begin
      ring_n = buffer_count_r;
    end
  end

  assign cand_busy  = locked_r[cand_r[BI_W-1:0]] || ready_r[cand_r[BI_W-1:0]];
  assign cand_after = ring_after({1'b0, cand_r}, ring_n);
  assign show_after = ring_after({1'b0, showing_r}, ring_n);
  assign steps_inc  = steps_r + 1'b1;

  always_comb begin
    state_nxt        = state_r;
    buffer_count_nxt = buffer_count_r;
    showing_nxt      = showing_r;
    locked_nxt       = locked_r;
    ready_nxt        = ready_r;
    valid_nxt        = valid_r;
    slot_nxt         = slot_r;
    span_nxt         = span_r;
    cand_nxt         = cand_r;
    steps_nxt        = steps_r;
    idx_nxt          = idx_r;
    stamp_nxt        = stamp_r;
    status_nxt       = status_r;
    granted_nxt      = granted_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_granted_nxt  = out_granted_r;
    out_showing_nxt  = out_showing_r;
    out_span_nxt     = out_span_r;
    mem_we           = 1'b0;

    if (cfg_wr && cfg_paddr[2] == REG_BUFFER_COUNT) begin
      buffer_count_nxt = cfg_pwdata[CNT_W-1:0];
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_nxt     = in_tdata[4:0];
          stamp_nxt   = in_tdata[36:5];
          status_nxt  = ST_OK;
          granted_nxt = '0;
          cand_nxt    = show_after[IDX_W-1:0];
          steps_nxt   = '0;
          case (in_tuser)
            OP_ACQUIRE: state_nxt = S_SEARCH;
            OP_SUBMIT:  state_nxt = S_SUBMIT;
            OP_VBLANK:  state_nxt = S_VBLANK;
            default:    state_nxt = S_OUT;
          endcase
        end
      end
      S_SEARCH: begin
        if (!cand_busy) begin
          locked_nxt[cand_r[BI_W-1:0]] = 1'b1;
          granted_nxt = cand_r;
          status_nxt  = ST_OK;
          state_nxt   = S_OUT;
        end else if (steps_inc >= ring_n || cand_after[IDX_W-1:0] == showing_r) begin
          status_nxt = ST_NONE_FREE;
          state_nxt  = S_OUT;
        end else begin
          steps_nxt = steps_inc;
          cand_nxt  = cand_after[IDX_W-1:0];
        end
      end
      S_SUBMIT: begin
        if ({1'b0, idx_r} >= ring_n) begin
          status_nxt = ST_BAD_INDEX;
        end else begin
          locked_nxt[idx_r[BI_W-1:0]] = 1'b0;
          ready_nxt[idx_r[BI_W-1:0]]  = 1'b1;
          if (valid_r[slot_r]) begin
            span_nxt = stamp_r - rd_data_r;
          end
          mem_we            = 1'b1;
          valid_nxt[slot_r] = 1'b1;
          slot_nxt          = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_VBLANK: begin
        if (ready_r[show_after[BI_W-1:0]]) begin
          showing_nxt                     = show_after[IDX_W-1:0];
          ready_nxt[show_after[BI_W-1:0]] = 1'b0;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_granted_nxt = granted_r;
          out_showing_nxt = showing_r;
          out_span_nxt    = span_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      buffer_count_r <= BUFFER_COUNT_RESET;
      showing_r      <= '0;
      locked_r       <= '0;
      ready_r        <= '0;
      valid_r        <= '0;
      slot_r         <= '0;
      span_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      buffer_count_r <= buffer_count_nxt;
      showing_r      <= showing_nxt;
      locked_r       <= locked_nxt;
      ready_r        <= ready_nxt;
      valid_r        <= valid_nxt;
      slot_r         <= slot_nxt;
      span_r         <= span_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    cand_r        <= cand_nxt;
    steps_r       <= steps_nxt;
    idx_r         <= idx_nxt;
    stamp_r       <= stamp_nxt;
    status_r      <= status_nxt;
    granted_r     <= granted_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_showing_r <= out_showing_nxt;
    out_span_r    <= out_span_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stamp_mem[slot_r] <= stamp_r;
    end
    rd_data_r <= stamp_mem[slot_r];
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'b0, out_span_r, out_showing_r, out_granted_r};
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_BUFFER_COUNT) ?
                      {{(CFG_DW - CNT_W){1'b0}}, buffer_count_r} : '0;

  a_masks_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    (locked_r & ready_r) == '0)
    else $error("buffer both locked and ready");

  a_showing_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    showing_r < IDX_W'(MAX_BUFFERS - 1) || showing_r == IDX_W'(MAX_BUFFERS - 1))
    else $error("showing index beyond ring");

  a_grant_locks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && !cand_busy) |=>
      (state_r == S_OUT && status_r == ST_OK && locked_r[$past(cand_r[BI_W-1:0])]))
    else $error("free buffer found but not granted");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result loaded outside output state");

endmodule
`default_nettype wire

// ===== verif/frame_chain_checker.sv =====
// Checker for the swap chain unit: predicts each result item and compares it with the output.
module frame_chain_checker
  import fbsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [39:0]       in_tdata,   // buffer_index[4:0], timestamp[36:5], zero pad
  input  logic [1:0]        in_tuser,   // operation[1:0]
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [47:0]       out_tdata,  // granted_index[4:0], showing_index[9:5],
                                        // window_ticks[41:10], zero pad
  input  logic [1:0]        out_tuser,  // status[1:0]
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  output int                mismatch_count,
  output int                pending_count
);

  localparam int RING_MAX = 32;
  localparam int WINDOW   = 32;
  localparam logic [CFG_AW-1:0] BUFFER_COUNT_ADDR = {REG_BUFFER_COUNT, 2'b00};

  typedef struct packed {
    status_t              status;
    logic [IDX_W-1:0]     granted;
    logic [IDX_W-1:0]     showing;
    logic [STAMP_W-1:0]   ticks;
  } chain_reply_t;

  logic [CNT_W-1:0]   ring_count;
  logic [IDX_W-1:0]   shown_buf;
  logic [31:0]        locked_bufs;
  logic [31:0]        ready_bufs;
  logic [STAMP_W-1:0] stamp_log [WINDOW];
  logic               stamp_held [WINDOW];
  logic [IDX_W-1:0]   stamp_ptr;
  logic [STAMP_W-1:0] span;
  chain_reply_t       chain_replies [$];

  function automatic int ring_len();
    if (ring_count == '0) return 1;
    if (int'(ring_count) > RING_MAX) return RING_MAX;
    return int'(ring_count);
  endfunction

  function automatic logic [IDX_W-1:0] step_ring(input logic [IDX_W-1:0] idx);
    int nxt;
    nxt = int'(idx) + 1;
    return (nxt >= ring_len()) ? '0 : IDX_W'(nxt);
  endfunction

  function automatic chain_reply_t apply_chain_op(input logic [1:0] op,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic [STAMP_W-1:0] stamp);
    chain_reply_t       r;
    logic [IDX_W-1:0]   cand;
    int                 n;
    r = '{status: ST_OK, granted: '0, showing: '0, ticks: '0};
    n = ring_len();
    case (op)
      OP_ACQUIRE: begin
        r.status = ST_NONE_FREE;
        cand = step_ring(shown_buf);
        for (int steps = 0; steps < n; steps++) begin
          if (!locked_bufs[cand] && !ready_bufs[cand]) begin
            locked_bufs[cand] = 1'b1;
            r.granted = cand;
            r.status = ST_OK;
            break;
          end
          cand = step_ring(cand);
          if (cand == shown_buf) break;
        end
      end
      OP_SUBMIT: begin
        if (int'(idx) >= n) begin
          r.status = ST_BAD_INDEX;
        end else begin
          locked_bufs[idx] = 1'b0;
          ready_bufs[idx] = 1'b1;
          if (stamp_held[stamp_ptr]) span = stamp - stamp_log[stamp_ptr];
          stamp_log[stamp_ptr] = stamp;
          stamp_held[stamp_ptr] = 1'b1;
          stamp_ptr = (int'(stamp_ptr) == WINDOW - 1) ? '0 : stamp_ptr + 1'b1;
        end
      end
      OP_VBLANK: begin
        cand = step_ring(shown_buf);
        if (ready_bufs[cand]) begin
          shown_buf = cand;
          ready_bufs[cand] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    r.showing = shown_buf;
    r.ticks = span;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    chain_reply_t want;
    if (!rst_n) begin
      ring_count = BUFFER_COUNT_RESET;
      shown_buf = '0;
      locked_bufs = '0;
      ready_bufs = '0;
      for (int i = 0; i < WINDOW; i++) begin
        stamp_log[i] = '0;
        stamp_held[i] = 1'b0;
      end
      stamp_ptr = '0;
      span = '0;
      chain_replies.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == BUFFER_COUNT_ADDR)
        ring_count = cfg_pwdata[CNT_W-1:0];
      if (out_tvalid && out_tready) begin
        if (chain_replies.size() == 0) begin
          $display("%0t: result item with none expected, actual status %0d data 0x%0h",
                   $time, out_tuser, out_tdata);
          mismatch_count++;
        end else begin
          want = chain_replies.pop_front();
          check_field("status", 32'(want.status), 32'(out_tuser));
          check_field("granted_index", 32'(want.granted), 32'(out_tdata[4:0]));
          check_field("showing_index", 32'(want.showing), 32'(out_tdata[9:5]));
          check_field("window_ticks", want.ticks, out_tdata[41:10]);
        end
      end
      if (in_tvalid && in_tready)
        chain_replies.push_back(apply_chain_op(in_tuser, in_tdata[4:0], in_tdata[36:5]));
    end
    pending_count <= chain_replies.size();
  end

endmodule

// ===== verif/tb_frame_buffer_swap_chain_unit.sv =====
// Testbench top: drives items and ring size writes into the swap chain unit, gives the verdict.
module tb_frame_buffer_swap_chain_unit;
  import fbsc_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [CFG_AW-1:0] BUFFER_COUNT_ADDR = {REG_BUFFER_COUNT, 2'b00};
  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_ITEMS = 60;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata = '0;    // buffer_index[4:0], timestamp[36:5], zero pad
  logic [1:0]        in_tuser = '0;    // operation[1:0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [47:0]       out_tdata;        // granted_index[4:0], showing_index[9:5],
                                       // window_ticks[41:10], zero pad
  logic [1:0]        out_tuser;        // status[1:0]
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int                mismatch_count;
  int                pending_count;
  int                quiet_cycles = 0;
  int                ring_now = 32;
  logic              idling = 1'b1;
  logic [31:0]       tick = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_buffer_swap_chain_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  frame_chain_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : sink
    while (!rst_n) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (idling) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  task automatic send_op(input logic [1:0] op, input logic [4:0] idx, input logic [31:0] stamp);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {3'b000, stamp, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic set_ring_count(input logic [CNT_W-1:0] value);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= BUFFER_COUNT_ADDR;
    cfg_pwdata <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    ring_now = (value == '0) ? 1 : (int'(value) > 32) ? 32 : int'(value);
  endtask

  task automatic run_random(input int count);
    int          r;
    logic [4:0]  idx;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 4) != 0) idx = 5'($urandom_range(0, ring_now - 1));
      else idx = 5'($urandom_range(0, 31));
      if ($urandom_range(0, 9) == 0) tick = $urandom;
      else tick = tick + $urandom_range(1, 4000);
      if (r < 35) send_op(OP_ACQUIRE, 5'($urandom), $urandom);
      else if (r < 68) send_op(OP_SUBMIT, idx, tick);
      else if (r < 95) send_op(OP_VBLANK, 5'($urandom), $urandom);
      else send_op(OP_SPARE, 5'($urandom), $urandom);
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_op(OP_VBLANK, 5'd0, 32'd0);
    send_op(OP_SPARE, 5'd31, 32'hFFFF_FFFF);
    send_op(OP_ACQUIRE, 5'd0, 32'd0);
    send_op(OP_SUBMIT, 5'd1, 32'd0);
    send_op(OP_VBLANK, 5'd0, 32'd0);
    send_op(OP_SUBMIT, 5'd31, 32'hFFFF_FFFF);
    send_op(OP_ACQUIRE, 5'd31, 32'hFFFF_FFFF);
    send_op(OP_SUBMIT, 5'd5, 32'h8000_0000);

    set_ring_count(6'd0);
    send_op(OP_ACQUIRE, 5'd0, 32'd0);
    send_op(OP_ACQUIRE, 5'd0, 32'd0);
    send_op(OP_SUBMIT, 5'd0, 32'h0000_0010);
    send_op(OP_SUBMIT, 5'd1, 32'h0000_0020);
    send_op(OP_VBLANK, 5'd0, 32'd0);
    send_op(OP_ACQUIRE, 5'd0, 32'd0);

    set_ring_count(6'd63);
    send_op(OP_ACQUIRE, 5'd0, 32'd0);
    set_ring_count(6'd2);
    send_op(OP_ACQUIRE, 5'd0, 32'd0);
    send_op(OP_ACQUIRE, 5'd0, 32'd0);
    send_op(OP_ACQUIRE, 5'd0, 32'd0);
    send_op(OP_SUBMIT, 5'd2, 32'h0000_0030);
    send_op(OP_VBLANK, 5'd0, 32'd0);

    set_ring_count(6'd4);
    run_random(PHASE_ITEMS);
    set_ring_count(6'd1);
    run_random(PHASE_ITEMS);
    set_ring_count(6'd32);
    run_random(PHASE_ITEMS);
    drain();
    run_random(PHASE_ITEMS);
    set_ring_count(6'd0);
    run_random(PHASE_ITEMS / 2);
    set_ring_count(6'd7);
    run_random(PHASE_ITEMS);
    set_ring_count(6'd63);
    run_random(PHASE_ITEMS);
    set_ring_count(6'd2);
    run_random(PHASE_ITEMS / 2);
    set_ring_count(6'($urandom_range(1, 32)));
    run_random(PHASE_ITEMS);
    set_ring_count(6'd32);
    idling = 1'b0;
    run_random(PHASE_ITEMS + 20);

    drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/fbsc_pkg.sv
sv/frame_buffer_swap_chain_unit.sv
verif/frame_chain_checker.sv
verif/tb_frame_buffer_swap_chain_unit.sv
